// ----- design/fbpa_pkg.sv -----
`default_nettype none
package fbpa_pkg;
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_EXHAUSTED = 3'd1,
		ST_CORRUPT   = 3'd2,
		ST_NULL      = 3'd3,
		ST_RANGE     = 3'd4,
		ST_DOUBLE    = 3'd5,
		ST_FULL      = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		REG_BASE  = 2'd0,
		REG_SIZE  = 2'd1,
		REG_COUNT = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_INIT,
		B_DIV,
		B_ALLOC,
		B_FREE,
		B_CHK,
		B_MUL,
		B_OUT
	} bstate_t;

	localparam int unsigned ADDR_W     = 32;
	localparam int unsigned MAX_BLOCKS = 256;

	typedef struct packed {
		logic              op;
		logic [ADDR_W-1:0] free_address;
	} req_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [ADDR_W-1:0] block_address;
		logic [7:0]        block_index;
		logic [8:0]        avail_count;
		logic [23:0]       pool_bytes;
	} rsp_t;
endpackage
`default_nettype wire

// ----- design/fixed_block_pool_allocator_top.sv -----
`default_nettype none
// Fixed-size block pool allocator. Each request is an allocate (op 0) or a
// free (op 1 with an address) and yields one response. Requests enter a
// two-entry queue; the back end handles one at a time. A free runs a radix-2
// divider that finds the block index one bit per cycle. After reset and after
// each block_count write the free stack is refilled and the used bits cleared,
// during which no request is taken. Configuration is taken only while the
// back end is idle and no request or response is waiting.
module fixed_block_pool_allocator_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,   // op[0], free_address[32:1], zero[39:33]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [79:0]      m_tdata,   // status, block_address, block_index,
	                                    // avail_count, pool_bytes, zero pad
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	fbpa_pkg::req_t in_req, q_req;
	fbpa_pkg::rsp_t rsp;
	logic q_valid, q_ready;

	assign in_req.op = s_tdata[0];
	assign in_req.free_address = s_tdata[32:1];

	fbpa_queue #(.DEPTH_LOG(1)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready), .in_data(in_req),
		.out_valid(q_valid), .out_ready(q_ready), .out_data(q_req)
	);

	fbpa_back u_back (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.req_valid(q_valid), .req_ready(q_ready), .req(q_req),
		.rsp_valid(m_tvalid), .rsp_ready(m_tready), .rsp(rsp)
	);

	assign m_tdata = {4'b0, rsp.pool_bytes, rsp.avail_count, rsp.block_index,
		rsp.block_address, rsp.status};
endmodule
`default_nettype wire

// ----- design/fbpa_queue.sv -----
`default_nettype none
module fbpa_queue #(
	parameter int unsigned DEPTH_LOG = 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire fbpa_pkg::req_t in_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output fbpa_pkg::req_t     out_data
);
	localparam int unsigned DEPTH = 1 << DEPTH_LOG;
	fbpa_pkg::req_t mem_q [DEPTH];
	logic [DEPTH_LOG-1:0] wp_q, rp_q;
	logic [DEPTH_LOG:0]   cnt_q;
	logic push, pop;

	assign in_ready  = (cnt_q != (DEPTH_LOG+1)'(DEPTH));
	assign out_valid = (cnt_q != '0);
	assign out_data  = mem_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop  = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop)  rp_q <= rp_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_data;
	end
endmodule
`default_nettype wire

// ----- design/fbpa_back.sv -----
`default_nettype none
module fbpa_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_valid,
	output logic                cfg_ready,
	input  wire logic [1:0]     cfg_index,
	input  wire logic [31:0]    cfg_data,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire fbpa_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output fbpa_pkg::rsp_t      rsp
);
	localparam int unsigned MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS;
	localparam int unsigned IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);

	fbpa_pkg::bstate_t st_q, st_d;
	logic [31:0] base_q;
	logic [15:0] size_q;
	logic [8:0]  count_q;
	logic [CW-1:0] total_q;
	logic [IW-1:0] stk_q [MAX_BLOCKS];
	logic used_q [MAX_BLOCKS];
	logic used_s1;
	logic [IW:0] ini_q;
	logic [31:0] rem_q, quo_q, off_q;
	logic [5:0] bit_q;
	logic [IW-1:0] rd_s1;
	logic [2:0] stat_q;
	logic [31:0] addr_q;
	logic [7:0] bidx_q;
	logic [31:0] mul_q;
	logic [23:0] tb_q;
	logic [IW-1:0] idx_q;
	logic out_q;

	logic [15:0] esize;
	logic [CW-1:0] ecount;
	logic [32:0] trial;
	logic [31:0] rem_sh;

	assign esize  = (size_q == '0) ? 16'd1 : size_q;
	assign ecount = (count_q > 9'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : CW'(count_q);
	assign rem_sh = {rem_q[30:0], off_q[31]};
	assign trial  = {1'b0, rem_sh} - {17'b0, esize};

	assign cfg_ready = (st_q == fbpa_pkg::B_IDLE) && !req_valid && !out_q;
	assign req_ready = (st_q == fbpa_pkg::B_IDLE) && !out_q;
	assign rsp_valid = out_q;

	always_comb begin
		st_d = st_q;
		case (st_q)
			fbpa_pkg::B_IDLE:
				if (cfg_valid && cfg_ready && cfg_index == fbpa_pkg::REG_COUNT) st_d = fbpa_pkg::B_INIT;
				else if (req_valid && req_ready) st_d = req.op ? fbpa_pkg::B_DIV : fbpa_pkg::B_ALLOC;
			fbpa_pkg::B_INIT:  if (ini_q == (IW+1)'(MAX_BLOCKS - 1)) st_d = fbpa_pkg::B_IDLE;
			fbpa_pkg::B_DIV:   if (bit_q == 6'd31) st_d = fbpa_pkg::B_FREE;
			fbpa_pkg::B_ALLOC: st_d = fbpa_pkg::B_MUL;
			fbpa_pkg::B_MUL:   st_d = fbpa_pkg::B_OUT;
			fbpa_pkg::B_FREE:  st_d = fbpa_pkg::B_CHK;
			fbpa_pkg::B_CHK:   st_d = fbpa_pkg::B_OUT;
			fbpa_pkg::B_OUT:   st_d = fbpa_pkg::B_IDLE;
			default:           st_d = fbpa_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		rsp.status        = stat_q;
		rsp.block_address = addr_q;
		rsp.block_index   = bidx_q;
		rsp.avail_count   = 9'(total_q);
		rsp.pool_bytes    = tb_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= fbpa_pkg::B_INIT;
			base_q  <= '0;
			size_q  <= 16'd64;
			count_q <= 9'd256;
			total_q <= CW'(MAX_BLOCKS);
			ini_q   <= '0;
			out_q   <= 1'b0;
		end else begin
			st_q <= st_d;
			if (out_q && rsp_ready) out_q <= 1'b0;
			case (st_q)
				fbpa_pkg::B_IDLE: begin
					if (cfg_valid && cfg_ready) begin
						case (cfg_index)
							fbpa_pkg::REG_BASE: base_q <= cfg_data;
							fbpa_pkg::REG_SIZE: size_q <= cfg_data[15:0];
							fbpa_pkg::REG_COUNT: begin
								count_q <= cfg_data[8:0];
								ini_q   <= '0;
								total_q <= (cfg_data[8:0] > 9'(MAX_BLOCKS)) ?
									CW'(MAX_BLOCKS) : CW'(cfg_data[8:0]);
							end
							default: ;
						endcase
					end
				end
				fbpa_pkg::B_INIT: ini_q <= ini_q + 1'b1;
				fbpa_pkg::B_CHK: begin
					if (stat_q == fbpa_pkg::ST_OK && used_s1 && total_q < ecount)
						total_q <= total_q + 1'b1;
				end
				fbpa_pkg::B_ALLOC: begin
					if (total_q != '0 && CW'(rd_s1) < ecount)
						total_q <= total_q - 1'b1;
				end
				fbpa_pkg::B_OUT: out_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == fbpa_pkg::B_INIT) stk_q[ini_q[IW-1:0]] <= ini_q[IW-1:0];
		else if (st_q == fbpa_pkg::B_CHK && stat_q == fbpa_pkg::ST_OK && used_s1
			&& total_q < ecount)
			stk_q[total_q[IW-1:0]] <= idx_q;
		if (st_q == fbpa_pkg::B_INIT) used_q[ini_q[IW-1:0]] <= 1'b0;
		else if (st_q == fbpa_pkg::B_ALLOC && total_q != '0 && CW'(rd_s1) < ecount)
			used_q[rd_s1] <= 1'b1;
		else if (st_q == fbpa_pkg::B_CHK && stat_q == fbpa_pkg::ST_OK && used_s1)
			used_q[idx_q] <= 1'b0;
		used_s1 <= used_q[quo_q[IW-1:0]];
		rd_s1 <= stk_q[total_q[IW-1:0] - 1'b1];
		tb_q  <= 24'(ecount) * 24'(esize);
		case (st_q)
			fbpa_pkg::B_IDLE: begin
				if (req_valid && req_ready) begin
					off_q  <= req.free_address - base_q;
					rem_q  <= '0;
					quo_q  <= '0;
					bit_q  <= '0;
					addr_q <= '0;
					bidx_q <= '0;
					stat_q <= (req.free_address == '0) ? fbpa_pkg::ST_NULL : fbpa_pkg::ST_OK;
				end
			end
			fbpa_pkg::B_DIV: begin
				off_q <= {off_q[30:0], 1'b0};
				bit_q <= bit_q + 1'b1;
				if (!trial[32]) begin
					rem_q <= trial[31:0];
					quo_q <= {quo_q[30:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[30:0], 1'b0};
				end
			end
			fbpa_pkg::B_FREE: begin
				idx_q <= quo_q[IW-1:0];
				if (stat_q == fbpa_pkg::ST_OK) begin
					if (rem_q != '0 || quo_q >= 32'(ecount)) stat_q <= fbpa_pkg::ST_RANGE;
					else bidx_q <= 8'(quo_q);
				end
			end
			fbpa_pkg::B_CHK: begin
				if (stat_q == fbpa_pkg::ST_OK) begin
					if (!used_s1) stat_q <= fbpa_pkg::ST_DOUBLE;
					else if (total_q >= ecount) stat_q <= fbpa_pkg::ST_FULL;
				end
			end
			fbpa_pkg::B_ALLOC: begin
				idx_q <= rd_s1;
				mul_q <= 32'(rd_s1) * 32'(esize);
				if (total_q == '0) stat_q <= fbpa_pkg::ST_EXHAUSTED;
				else if (CW'(rd_s1) >= ecount) stat_q <= fbpa_pkg::ST_CORRUPT;
				else stat_q <= fbpa_pkg::ST_OK;
			end
			fbpa_pkg::B_MUL: begin
				if (stat_q == fbpa_pkg::ST_OK) begin
					addr_q <= base_q + mul_q;
					bidx_q <= 8'(idx_q);
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// ----- test/tb_fixed_block_pool_allocator_top.sv -----
`timescale 1ns / 1ps
module tb_fixed_block_pool_allocator_top;
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;   // op[0], free_address[32:1], zero[39:33]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;        // status, block_address, block_index, avail_count, pool_bytes
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	fixed_block_pool_allocator_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic [39:0]     pending_req[$];
	fbpa_pkg::rsp_t  expected_rsp[$];
	int              errors = 0;
	int unsigned     send_idle = 38;
	int unsigned     recv_idle = 79;
	logic            stall_kick = 1'b0;
	int unsigned     stall_left = 0;

	logic [31:0] pool_base_m;
	logic [15:0] block_size_m;
	logic [8:0]  block_count_m;
	logic [7:0]  stack_m[256];
	bit          used_m[256];
	int unsigned avail_m;

	function automatic int unsigned eff_count();
		return (block_count_m > 9'd256) ? 256 : block_count_m;
	endfunction

	function automatic int unsigned eff_size();
		return (block_size_m == 16'd0) ? 1 : block_size_m;
	endfunction

	function automatic void reinit_pool();
		for (int i = 0; i < 256; i++) begin
			stack_m[i] = i[7:0];
			used_m[i] = 1'b0;
		end
		avail_m = eff_count();
	endfunction

	function automatic fbpa_pkg::rsp_t pool_step(logic [39:0] d);
		int unsigned cnt, sz, idx;
		logic [31:0] faddr, off;
		fbpa_pkg::rsp_t r;
		cnt = eff_count();
		sz = eff_size();
		faddr = d[32:1];
		r = '0;
		r.status = fbpa_pkg::ST_OK;
		if (d[0] == 1'b0) begin
			if (avail_m == 0) begin
				r.status = fbpa_pkg::ST_EXHAUSTED;
			end else begin
				idx = stack_m[avail_m - 1];
				if (idx >= cnt) begin
					r.status = fbpa_pkg::ST_CORRUPT;
				end else begin
					avail_m = avail_m - 1;
					used_m[idx] = 1'b1;
					r.block_address = pool_base_m + idx * sz;
					r.block_index = idx[7:0];
				end
			end
		end else if (faddr == 32'd0) begin
			r.status = fbpa_pkg::ST_NULL;
		end else begin
			off = faddr - pool_base_m;
			idx = off / sz;
			if ((off % sz) != 0 || idx >= cnt) begin
				r.status = fbpa_pkg::ST_RANGE;
			end else if (!used_m[idx]) begin
				r.status = fbpa_pkg::ST_DOUBLE;
				r.block_index = idx[7:0];
			end else begin
				used_m[idx] = 1'b0;
				r.block_index = idx[7:0];
				if (avail_m >= cnt) begin
					r.status = fbpa_pkg::ST_FULL;
				end else begin
					stack_m[avail_m] = idx[7:0];
					avail_m = avail_m + 1;
				end
			end
		end
		r.avail_count = avail_m[8:0];
		r.pool_bytes = 24'(cnt * sz);
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready)
				expected_rsp.push_back(pool_step(s_tdata));
			if (!s_tvalid || s_tready) begin
				if (pending_req.size() > 0 && $urandom_range(99) >= send_idle) begin
					s_tdata <= pending_req.pop_front();
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			stall_left <= 0;
		else if (stall_kick)
			stall_left <= 400;
		else if (stall_left > 0)
			stall_left <= stall_left - 1;
	end

	always @(posedge clk or negedge arst_n) begin
		fbpa_pkg::rsp_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_rsp.size() == 0) begin
					report_mismatch("unexpected response", m_tdata[31:0], 32'd0);
				end else begin
					want = expected_rsp.pop_front();
					if (m_tdata[2:0] != want.status)
						report_mismatch("status", 32'(m_tdata[2:0]), 32'(want.status));
					if (m_tdata[34:3] != want.block_address)
						report_mismatch("block_address", m_tdata[34:3], want.block_address);
					if (m_tdata[42:35] != want.block_index)
						report_mismatch("block_index", 32'(m_tdata[42:35]),
							32'(want.block_index));
					if (m_tdata[51:43] != want.avail_count)
						report_mismatch("avail_count", 32'(m_tdata[51:43]),
							32'(want.avail_count));
					if (m_tdata[75:52] != want.pool_bytes)
						report_mismatch("pool_bytes", 32'(m_tdata[75:52]),
							32'(want.pool_bytes));
				end
			end
			m_tready <= (stall_left == 0) && ($urandom_range(99) >= recv_idle);
		end
	end

	task automatic write_reg(fbpa_pkg::reg_idx_t idx, logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			fbpa_pkg::REG_BASE: pool_base_m = val;
			fbpa_pkg::REG_SIZE: block_size_m = val[15:0];
			default: begin
				block_count_m = val[8:0];
				reinit_pool();
			end
		endcase
	endtask

	task automatic configure(logic [31:0] base, logic [31:0] sz, logic [31:0] cnt);
		write_reg(fbpa_pkg::REG_BASE, base);
		write_reg(fbpa_pkg::REG_SIZE, sz);
		write_reg(fbpa_pkg::REG_COUNT, cnt);
	endtask

	function automatic logic [39:0] pack_req(logic op, logic [31:0] addr);
		return {7'd0, addr, op};
	endfunction

	function automatic logic [31:0] block_addr(int unsigned k);
		return pool_base_m + k * eff_size();
	endfunction

	task automatic wait_drained();
		@(posedge clk);
		while (pending_req.size() > 0 || s_tvalid || expected_rsp.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic queue_random(int n);
		int unsigned pick, cnt;
		cnt = eff_count();
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if (pick < 45)
				pending_req.push_back(pack_req(1'b0, $urandom()));
			else if (pick < 80)
				pending_req.push_back(pack_req(1'b1, block_addr($urandom_range(cnt + 1))));
			else if (pick < 85)
				pending_req.push_back(pack_req(1'b1, 32'd0));
			else if (pick < 92)
				pending_req.push_back(pack_req(1'b1, block_addr($urandom_range(cnt)) + 1));
			else
				pending_req.push_back(pack_req(1'b1, $urandom()));
		end
	endtask

	initial begin
		pool_base_m = 32'd0;
		block_size_m = 16'd64;
		block_count_m = 9'd256;
		reinit_pool();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (300) @(posedge clk);

		pending_req.push_back(pack_req(1'b0, 32'hFFFF_FFFF));
		pending_req.push_back(pack_req(1'b0, 32'd0));
		pending_req.push_back(pack_req(1'b1, 32'd0));
		pending_req.push_back(pack_req(1'b1, 32'd1));
		pending_req.push_back(pack_req(1'b1, 32'd256 * 64));
		pending_req.push_back(pack_req(1'b1, 32'hFFFF_FFFF));
		pending_req.push_back(pack_req(1'b1, 32'd255 * 64));
		pending_req.push_back(pack_req(1'b1, 32'd255 * 64));
		pending_req.push_back(pack_req(1'b1, 32'd254 * 64));
		pending_req.push_back(pack_req(1'b1, 32'd3 * 64));
		wait_drained();

		configure(32'h0000_1000, 32'd16, 32'd4);
		for (int i = 0; i < 6; i++)
			pending_req.push_back(pack_req(1'b0, 32'd0));
		for (int i = 0; i < 5; i++)
			pending_req.push_back(pack_req(1'b1, 32'h1000 + i * 16));
		queue_random(60);
		wait_drained();

		configure(32'hFFFF_FFF0, 32'h0000_FFFF, 32'd256);
		queue_random(100);
		@(posedge clk);
		stall_kick <= 1'b1;
		@(posedge clk);
		stall_kick <= 1'b0;
		wait_drained();

		configure(32'h0000_0000, 32'd0, 32'd0);
		queue_random(30);
		wait_drained();

		configure($urandom(), 32'd1, 32'd511);
		queue_random(100);
		wait_drained();

		send_idle = 79;
		recv_idle = 38;
		for (int p = 0; p < 2; p++) begin
			configure($urandom(), $urandom_range(1, 65535), $urandom_range(1, 256));
			queue_random(100);
			wait_drained();
		end

		send_idle = 0;
		recv_idle = 0;
		for (int p = 0; p < 2; p++) begin
			configure($urandom(), $urandom_range(1, 300), $urandom_range(1, 40));
			queue_random(100);
			wait_drained();
		end

		if (errors == 0)
			$display("fixed_block_pool_allocator_top test passed");
		else
			$display("fixed_block_pool_allocator_top test failed");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("fixed_block_pool_allocator_top test failed");
		$finish;
	end
endmodule
